/* design/lkvc_pkg.sv */
package lkvc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CAP_W-1:0]      CAP_RESET    = CAP_W'(16);
  localparam logic [CFG_ADDR_W-1:0] REG_CAP_ADDR = CFG_ADDR_W'(0);

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);

  typedef struct packed {
    logic                     mode;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } out_item_t;

endpackage

/* design/lkvc_cfg_regs.sv */
module lkvc_cfg_regs import lkvc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CAP_W-1:0]      capacity
);

  logic [CAP_W-1:0] cap_r;
  logic             wr_en;

  assign wr_en  = psel && penable && pwrite && (paddr == REG_CAP_ADDR);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (wr_en) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_CAP_ADDR) begin
      prdata = CFG_DATA_W'(cap_r);
    end
  end

  assign capacity = cap_r;

endmodule

/* design/lkvc_store.sv */
module lkvc_store import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned FILL_W = $clog2(ENTRIES + 1),
  localparam int unsigned CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  in_item_t           req,
  input  logic [CAP_W-1:0]   capacity,
  output out_item_t          rsp,
  output logic [ENTRIES-1:0] ent_valid,
  output logic [FILL_W-1:0]  fill_cnt
);

  logic [ENTRIES-1:0]       valid_r;
  logic signed [KEY_W-1:0]  key_r  [ENTRIES];
  logic signed [DATA_W-1:0] val_r  [ENTRIES];
  logic [RANK_W-1:0]        rank_r [ENTRIES];
  logic [FILL_W-1:0]        fill_r;

  logic [ENTRIES-1:0]       match;
  logic [ENTRIES-1:0]       victim;
  logic [ENTRIES-1:0]       kept;
  logic [ENTRIES-1:0]       free_slots;
  logic [ENTRIES-1:0]       slot;
  logic                     hit;
  logic [RANK_W-1:0]        hit_rank;
  logic signed [DATA_W-1:0] hit_val;
  logic [CMP_W-1:0]         cap_ext;
  logic [CMP_W-1:0]         eff_cap;
  logic                     need_evict;
  logic [FILL_W-1:0]        last_rank;
  logic                     do_insert;

  // lane compare, hit data gather and lru victim / free slot selection
  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req.key);
      if (match[i]) begin
        hit_rank = hit_rank | rank_r[i];
        hit_val  = hit_val | val_r[i];
      end
    end
    hit = |match;

    cap_ext = CMP_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    need_evict = CMP_W'(fill_r) >= eff_cap;
    last_rank  = fill_r - 1'b1;

    // valid ranks are always a permutation of 0 .. fill-1
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i] = need_evict && valid_r[i] && (FILL_W'(rank_r[i]) == last_rank);
    end
    kept       = valid_r & ~victim;
    free_slots = ~kept;
    slot       = free_slots & (~free_slots + 1'b1);

    do_insert = fire && (req.mode == MODE_WRITE) && !hit;

    rsp.hit = hit;
    if (req.mode == MODE_WRITE) begin
      rsp.read_value = '0;
    end else if (hit) begin
      rsp.read_value = hit_val;
    end else begin
      rsp.read_value = MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
    end else if (do_insert) begin
      valid_r <= kept | slot;
      if (!need_evict) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire && hit) begin
        if (match[i]) begin
          rank_r[i] <= '0;
          if (req.mode == MODE_WRITE) begin
            val_r[i] <= req.value;
          end
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end else if (do_insert) begin
        if (slot[i]) begin
          key_r[i]  <= req.key;
          val_r[i]  <= req.value;
          rank_r[i] <= '0;
        end else if (kept[i]) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
    end
  end

  assign ent_valid = valid_r;
  assign fill_cnt  = fill_r;

endmodule

/* design/lru_key_value_cache_core.sv */
// pipeline: a transaction is captured in the input register, then lookup and update write
// its result into the result register; a stalled output holds both registers
// throughput: one transaction per cycle while the output is not stalled, lookup and lru update done in one pass
// reset: synchronous, active low; clears valid bits and fill count, capacity to 16
// key, value and rank storage is not cleared, no clearing pass
module lru_key_value_cache_core import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned FILL_W = $clog2(ENTRIES + 1);

  logic               s1_vld_r;
  in_item_t           s1_item_r;
  logic               out_vld_r;
  out_item_t          out_item_r;
  logic               adv;
  logic               fire;
  logic [CAP_W-1:0]   capacity;
  out_item_t          rsp;
  logic [ENTRIES-1:0] ent_valid;
  logic [FILL_W-1:0]  fill_cnt;

  lkvc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .capacity (capacity)
  );

  lkvc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .req       (s1_item_r),
    .capacity  (capacity),
    .rsp       (rsp),
    .ent_valid (ent_valid),
    .fill_cnt  (fill_cnt)
  );

  assign adv      = !out_vld_r || !out_stall;
  assign fire     = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      out_item_r <= rsp;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ent_valid) == int'(fill_cnt))
    else $error("fill count differs from number of valid entries");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (fill_cnt == '0) && (ent_valid == '0))
    else $error("reset did not empty the cache");

  a_idle_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(fill_cnt) && $stable(ent_valid))
    else $error("cache contents changed without a transaction");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && out_vld_r && out_stall)
    else $error("input stalled while the pipeline could advance");

endmodule
